/* design/rchs_pkg.sv */
// Package with the shared constants, command codes and state type of the region histogram block.
`timescale 1ns / 1ps

package rchs_pkg;

    localparam int BINS_DEF        = 16;
    localparam int NUM_REGIONS_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 20;

    localparam int CHANNELS   = 3;
    localparam int FRAC_BITS  = 30;
    localparam int RID_W      = 10;
    localparam int CHAN_W     = 8;
    localparam int DIST_W     = 17;
    localparam int DIST_SHIFT = 15;
    localparam int ONE_Q16    = 65536;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_CNT,
        S_Q_CHK,
        S_Q_RD,
        S_Q_LAT,
        S_DIV_A,
        S_DIV_B,
        S_DIFF,
        S_SQR,
        S_DIV_T,
        S_DONE
    } t_state;

endpackage

/* design/region_color_histogram_chi_square.sv */
// Top level of the region color histogram block with its chi-square distance query.
`timescale 1ns / 1ps

// The block keeps a histogram of BINS bins for each of three color channels and a pixel
// count for each region, all in synchronous RAM. After reset, and after every clear
// request, a clearing pass writes zeros through the bin memory, one entry a cycle; no
// request is taken meanwhile. One request is worked on at a time. On an add request,
// since the bin memory has one write port, the three channel bins are read and written
// back one after another. A query of two valid, non-empty regions walks all 3*BINS bin
// pairs through one shared bit-serial divider that runs up to three divisions per pair.
// A finished result waits in an output register while the next request is taken.
module region_color_histogram_chi_square #(
    parameter int BINS        = rchs_pkg::BINS_DEF,
    parameter int NUM_REGIONS = rchs_pkg::NUM_REGIONS_DEF,
    parameter int COUNT_BITS  = rchs_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // region_a[9:0], region_b[19:10], chan0[27:20], chan1[35:28], chan2[43:36], zeros
    input  logic [47:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // distance[16:0], zeros
    output logic [23:0] o_m_axis_tdata,
    // empty_region[0]
    output logic        o_m_axis_tuser
);

    localparam int JN     = BINS * rchs_pkg::CHANNELS;
    localparam int BDEPTH = NUM_REGIONS * JN;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int CAW    = $clog2(NUM_REGIONS);
    localparam int JW     = $clog2(JN);
    localparam int BW     = $clog2(BINS);
    localparam int HW     = rchs_pkg::FRAC_BITS;
    localparam int NW     = (COUNT_BITS + HW > 2 * HW) ? COUNT_BITS + HW : 2 * HW;
    localparam int DW     = (COUNT_BITS + 2 > HW + 1) ? COUNT_BITS + 2 : HW + 1;
    localparam int SW     = HW + 4;
    localparam int CW     = COUNT_BITS;

    rchs_pkg::t_state r_state, n_state;

    logic [BAW-1:0]                r_clr, n_clr;
    logic [rchs_pkg::RID_W-1:0]    r_ra, n_ra, r_rb, n_rb;
    logic [BW-1:0]                 r_bin [0:2];
    logic [BW-1:0]                 n_bin [0:2];
    logic [1:0]                    r_ch, n_ch;
    logic [CW-1:0]                 r_na, n_na, r_nb, n_nb, r_cb, n_cb;
    logic [JW-1:0]                 r_j, n_j;
    logic [HW-1:0]                 r_ha, n_ha, r_hb, n_hb, r_d, n_d;
    logic [HW:0]                   r_s, n_s;
    logic [SW-1:0]                 r_sum, n_sum;
    logic                          r_empty, n_empty;
    logic                          r_div_start, n_div_start;
    logic [NW-1:0]                 r_div_num, n_div_num;
    logic [DW-1:0]                 r_div_den, n_div_den;
    logic                          r_out_valid, n_out_valid;
    logic [rchs_pkg::DIST_W-1:0]   r_out_dist, n_out_dist;
    logic                          r_out_empty, n_out_empty;

    logic          bin_we, cnt_we;
    logic [BAW-1:0] bin_waddr, bin_addr_a, bin_addr_b;
    logic [CW-1:0]  bin_wdata, cnt_wdata, bin_rd_a, bin_rd_b, cnt_rd_a, cnt_rd_b;
    logic [CAW-1:0] cnt_waddr, cnt_addr_a, cnt_addr_b;
    logic           div_done;
    logic [NW-1:0]  div_quo;
    logic [2*HW-1:0] sq;
    logic [SW-16:0]  dist_full;
    logic [31:0]     add_off;
    logic            accept;
    logic            ra_ok, rb_ok, in_ok;
    rchs_pkg::t_cmd  cmd;

    function automatic logic [BW-1:0] bin_of(input logic [rchs_pkg::CHAN_W-1:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'(BINS);
        return BW'(p >> 8);
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    assign cmd    = rchs_pkg::t_cmd'(i_s_axis_tuser);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign ra_ok  = 32'(r_ra) < 32'(NUM_REGIONS);
    assign rb_ok  = 32'(r_rb) < 32'(NUM_REGIONS);
    assign in_ok  = 32'(i_s_axis_tdata[9:0]) < 32'(NUM_REGIONS);
    assign sq     = r_d * r_d;
    assign dist_full = r_sum[SW-1:rchs_pkg::DIST_SHIFT];
    assign add_off = 32'(r_bin[r_ch]) * 32'(rchs_pkg::CHANNELS) + 32'(r_ch);

    always_comb begin
        if (r_state == rchs_pkg::S_ADD_RD || r_state == rchs_pkg::S_ADD_WR) begin
            bin_addr_a = BAW'(32'(r_ra) * 32'(JN) + add_off);
        end else begin
            bin_addr_a = BAW'(32'(r_ra) * 32'(JN) + 32'(r_j));
        end
    end
    assign bin_addr_b = BAW'(32'(r_rb) * 32'(JN) + 32'(r_j));
    assign cnt_addr_a = CAW'(r_ra);
    assign cnt_addr_b = CAW'(r_rb);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_bin       = r_bin;
        n_ch        = r_ch;
        n_na        = r_na;
        n_nb        = r_nb;
        n_cb        = r_cb;
        n_j         = r_j;
        n_ha        = r_ha;
        n_hb        = r_hb;
        n_d         = r_d;
        n_s         = r_s;
        n_sum       = r_sum;
        n_empty     = r_empty;
        n_div_start = 1'b0;
        n_div_num   = r_div_num;
        n_div_den   = r_div_den;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_dist  = r_out_dist;
        n_out_empty = r_out_empty;
        bin_we      = 1'b0;
        bin_waddr   = bin_addr_a;
        bin_wdata   = sat_inc(bin_rd_a);
        cnt_we      = 1'b0;
        cnt_waddr   = cnt_addr_a;
        cnt_wdata   = sat_inc(cnt_rd_a);
        o_s_axis_tready = 1'b0;

        unique case (r_state)
            rchs_pkg::S_CLEAR: begin
                bin_we    = 1'b1;
                bin_waddr = r_clr;
                bin_wdata = '0;
                cnt_we    = 32'(r_clr) < 32'(NUM_REGIONS);
                cnt_waddr = CAW'(r_clr);
                cnt_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == BAW'(BDEPTH - 1)) begin
                    n_state = rchs_pkg::S_IDLE;
                end
            end
            rchs_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (accept) begin
                    n_ra = i_s_axis_tdata[9:0];
                    n_rb = i_s_axis_tdata[19:10];
                    unique case (cmd)
                        rchs_pkg::CMD_ADD: begin
                            n_bin[0] = bin_of(i_s_axis_tdata[27:20]);
                            n_bin[1] = bin_of(i_s_axis_tdata[35:28]);
                            n_bin[2] = bin_of(i_s_axis_tdata[43:36]);
                            n_ch     = 2'd0;
                            if (in_ok) begin
                                n_state = rchs_pkg::S_ADD_RD;
                            end
                        end
                        rchs_pkg::CMD_QUERY: n_state = rchs_pkg::S_Q_CNT;
                        rchs_pkg::CMD_CLEAR: begin
                            n_clr   = '0;
                            n_state = rchs_pkg::S_CLEAR;
                        end
                        default: n_state = rchs_pkg::S_IDLE;
                    endcase
                end
            end
            rchs_pkg::S_ADD_RD: n_state = rchs_pkg::S_ADD_WR;
            rchs_pkg::S_ADD_WR: begin
                bin_we = 1'b1;
                cnt_we = (r_ch == 2'd0);
                if (r_ch == 2'd2) begin
                    n_state = rchs_pkg::S_IDLE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = rchs_pkg::S_ADD_RD;
                end
            end
            rchs_pkg::S_Q_CNT: n_state = rchs_pkg::S_Q_CHK;
            rchs_pkg::S_Q_CHK: begin
                n_na  = ra_ok ? cnt_rd_a : '0;
                n_nb  = rb_ok ? cnt_rd_b : '0;
                n_j   = '0;
                n_sum = '0;
                if (!ra_ok || !rb_ok || cnt_rd_a == '0 || cnt_rd_b == '0) begin
                    n_empty = 1'b1;
                    n_state = rchs_pkg::S_DONE;
                end else begin
                    n_empty = 1'b0;
                    n_state = rchs_pkg::S_Q_RD;
                end
            end
            rchs_pkg::S_Q_RD: n_state = rchs_pkg::S_Q_LAT;
            rchs_pkg::S_Q_LAT: begin
                n_cb        = bin_rd_b;
                n_div_start = 1'b1;
                n_div_num   = NW'(bin_rd_a) << HW;
                n_div_den   = DW'(r_na) + (DW'(r_na) << 1);
                n_state     = rchs_pkg::S_DIV_A;
            end
            rchs_pkg::S_DIV_A: begin
                if (div_done) begin
                    n_ha        = div_quo[HW-1:0];
                    n_div_start = 1'b1;
                    n_div_num   = NW'(r_cb) << HW;
                    n_div_den   = DW'(r_nb) + (DW'(r_nb) << 1);
                    n_state     = rchs_pkg::S_DIV_B;
                end
            end
            rchs_pkg::S_DIV_B: begin
                if (div_done) begin
                    n_hb    = div_quo[HW-1:0];
                    n_state = rchs_pkg::S_DIFF;
                end
            end
            rchs_pkg::S_DIFF: begin
                n_d     = (r_ha > r_hb) ? r_ha - r_hb : r_hb - r_ha;
                n_s     = {1'b0, r_ha} + {1'b0, r_hb};
                n_state = rchs_pkg::S_SQR;
            end
            rchs_pkg::S_SQR: begin
                if (r_s == '0) begin
                    if (r_j == JW'(JN - 1)) begin
                        n_state = rchs_pkg::S_DONE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = rchs_pkg::S_Q_RD;
                    end
                end else begin
                    n_div_start = 1'b1;
                    n_div_num   = NW'(sq);
                    n_div_den   = DW'(r_s);
                    n_state     = rchs_pkg::S_DIV_T;
                end
            end
            rchs_pkg::S_DIV_T: begin
                if (div_done) begin
                    n_sum = r_sum + SW'(div_quo[HW-1:0]);
                    if (r_j == JW'(JN - 1)) begin
                        n_state = rchs_pkg::S_DONE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = rchs_pkg::S_Q_RD;
                    end
                end
            end
            rchs_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_empty = r_empty;
                    if (r_empty) begin
                        n_out_dist = '0;
                    end else if (32'(dist_full) > 32'(rchs_pkg::ONE_Q16)) begin
                        n_out_dist = rchs_pkg::DIST_W'(rchs_pkg::ONE_Q16);
                    end else begin
                        n_out_dist = rchs_pkg::DIST_W'(dist_full);
                    end
                    n_state = rchs_pkg::S_IDLE;
                end
            end
            default: n_state = rchs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rchs_pkg::S_CLEAR;
            r_clr       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra        <= n_ra;
        r_rb        <= n_rb;
        r_bin       <= n_bin;
        r_ch        <= n_ch;
        r_na        <= n_na;
        r_nb        <= n_nb;
        r_cb        <= n_cb;
        r_j         <= n_j;
        r_ha        <= n_ha;
        r_hb        <= n_hb;
        r_d         <= n_d;
        r_s         <= n_s;
        r_sum       <= n_sum;
        r_empty     <= n_empty;
        r_div_num   <= n_div_num;
        r_div_den   <= n_div_den;
        r_out_dist  <= n_out_dist;
        r_out_empty <= n_out_empty;
    end

    rchs_ram #(
        .W     (CW),
        .DEPTH (BDEPTH)
    ) u_bin_ram (
        .i_clk     (i_clk),
        .i_we      (bin_we),
        .i_waddr   (bin_waddr),
        .i_wdata   (bin_wdata),
        .i_raddr_a (bin_addr_a),
        .o_rdata_a (bin_rd_a),
        .i_raddr_b (bin_addr_b),
        .o_rdata_b (bin_rd_b)
    );

    rchs_ram #(
        .W     (CW),
        .DEPTH (NUM_REGIONS)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_we      (cnt_we),
        .i_waddr   (cnt_waddr),
        .i_wdata   (cnt_wdata),
        .i_raddr_a (cnt_addr_a),
        .o_rdata_a (cnt_rd_a),
        .i_raddr_b (cnt_addr_b),
        .o_rdata_b (cnt_rd_b)
    );

    rchs_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_dist};
    assign o_m_axis_tuser  = r_out_empty;

`ifndef ASSERT_OFF
    a_no_request_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rchs_pkg::S_CLEAR) |-> !o_s_axis_tready)
        else $error("request taken during clearing pass");
    a_result_from_query : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == rchs_pkg::S_DONE)
        else $error("result without a finished query");
    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_dist == '0))
        else $error("empty region with nonzero distance");
    a_dist_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (32'(r_out_dist) <= 32'(rchs_pkg::ONE_Q16)))
        else $error("distance above one");
`endif

endmodule

/* design/rchs_ram.sv */
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module rchs_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    output logic [W-1:0]  o_rdata_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [0:DEPTH-1];
    logic [W-1:0] r_rdata_a;
    logic [W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* design/rchs_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module rchs_div #(
    parameter int NW = 60,
    parameter int DW = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int KW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [DW:0]   trial;
    logic          qbit;
    logic [DW:0]   diff;

    assign trial = {r_rem, r_num[NW-1]};
    assign qbit  = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == KW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], qbit};
            r_rem <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef ASSERT_OFF
    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
`endif

endmodule
